// ===== hw/rtl/esh_pkg.sv =====
package esh_pkg;

  localparam int GRID        = 90;
  localparam int CELL        = 9;
  localparam int MOD_PER_ROW = 10;

  localparam int CELLS  = GRID * GRID;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int CNT_W      = 32;
  localparam int E_W        = 16;
  localparam int T_W        = 32;
  localparam int MOD_W      = 8;
  localparam int PIX_W      = 8;
  localparam int RD_W       = 7;
  localparam int COORD_W    = 8;
  localparam int POS_W      = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // module / MOD_PER_ROW as multiply by rounded-up reciprocal
  localparam int DIV_SH  = 20;
  localparam int RECIP_W = 21;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((1 << DIV_SH) + MOD_PER_ROW - 1) / MOD_PER_ROW);
  localparam int PROD_W = MOD_W + RECIP_W;

  localparam logic [CNT_W-1:0] SAT_COUNT = '1;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_COUNTED = 2'd0;
  localparam kind_t KIND_DROPPED = 2'd1;
  localparam kind_t KIND_READOUT = 2'd2;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_ENERGY_LOW   = 3'd0;
  localparam cfg_idx_t REG_ENERGY_HIGH  = 3'd1;
  localparam cfg_idx_t REG_TIME_LOW     = 3'd2;
  localparam cfg_idx_t REG_TIME_HIGH    = 3'd3;
  localparam cfg_idx_t REG_TIME_LOW_ON  = 3'd4;
  localparam cfg_idx_t REG_TIME_HIGH_ON = 3'd5;

  typedef struct packed {
    logic [E_W-1:0] energy_low;
    logic [E_W-1:0] energy_high;
    logic [T_W-1:0] time_low;
    logic [T_W-1:0] time_high;
    logic           time_low_on;
    logic           time_high_on;
  } cfg_regs_t;

endpackage

// ===== hw/rtl/esh_in_if.sv =====
interface esh_in_if;
  import esh_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [E_W-1:0]   energy;
  logic [T_W-1:0]   stamp;
  logic [MOD_W-1:0] module_req;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic [RD_W-1:0]  read_x;
  logic [RD_W-1:0]  read_y;

  modport source (output valid, op, energy, stamp, module_req, pixel_x, pixel_y,
                  read_x, read_y, input ready);
  modport sink   (input valid, op, energy, stamp, module_req, pixel_x, pixel_y,
                  read_x, read_y, output ready);
endinterface

// ===== hw/rtl/esh_out_if.sv =====
interface esh_out_if;
  import esh_pkg::*;

  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [RD_W-1:0]  bin_x;
  logic [RD_W-1:0]  bin_y;
  logic [CNT_W-1:0] count;

  modport source (output valid, kind, bin_x, bin_y, count, input ready);
  modport sink   (input valid, kind, bin_x, bin_y, count, output ready);
endinterface

// ===== hw/rtl/esh_ram.sv =====
module esh_ram #(
  parameter int DEPTH = 8100,
  parameter int AW    = 13,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/esh_cfg.sv =====
module esh_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  esh_pkg::cfg_idx_t                cfg_idx,
  input  logic [esh_pkg::CFG_DATA_W-1:0]   cfg_data,
  output esh_pkg::cfg_regs_t               regs_o
);
  import esh_pkg::*;

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.energy_low   <= '0;
      regs_r.energy_high  <= '1;
      regs_r.time_low     <= '0;
      regs_r.time_high    <= '1;
      regs_r.time_low_on  <= 1'b0;
      regs_r.time_high_on <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ENERGY_LOW:   regs_r.energy_low   <= cfg_data[E_W-1:0];
        REG_ENERGY_HIGH:  regs_r.energy_high  <= cfg_data[E_W-1:0];
        REG_TIME_LOW:     regs_r.time_low     <= cfg_data[T_W-1:0];
        REG_TIME_HIGH:    regs_r.time_high    <= cfg_data[T_W-1:0];
        REG_TIME_LOW_ON:  regs_r.time_low_on  <= cfg_data[0];
        REG_TIME_HIGH_ON: regs_r.time_high_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign regs_o = regs_r;

endmodule

// ===== hw/rtl/event_sky_histogram_2d_unit.sv =====
// Event word: after acceptance it passes the divide, position, address, read and
// write-back states; a readout word goes straight to address. Write-back, which
// loads the result, waits on a stalled output. One word is handled at a time.
// Reset: synchronous, active low; then a clearing pass over the bin memory zeroes
// all 8100 (GRID*GRID) cells, no word accepted meanwhile.
module event_sky_histogram_2d_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  esh_in_if.sink                         in_ch,
  esh_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  esh_pkg::cfg_idx_t              cfg_idx,
  input  logic [esh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import esh_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_POS   = 3'd3;
  localparam logic [2:0] ST_ADDR  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_WB    = 3'd6;

  cfg_regs_t cfg;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic               op_r;
  logic               keep_r;
  logic [MOD_W-1:0]   mod_r;
  logic [PIX_W-1:0]   px_r, py_r;
  logic [PROD_W-1:0]  prod_r;
  logic [COORD_W-1:0] bx_r, by_r;
  logic [ADDR_W-1:0]  addr_r;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [RD_W-1:0]    out_x_r, out_y_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic               accept, in_window, out_load;
  logic [MOD_W-1:0]   quo, rem;
  logic [POS_W-1:0]   bx_full, by_full, addr_full;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CNT_W-1:0]   mem_wdata, mem_rdata, cnt_inc;

  esh_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .regs_o   (cfg)
  );

  esh_ram #(.DEPTH(CELLS), .AW(ADDR_W), .DW(CNT_W)) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (addr_r),
    .rdata_r (mem_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign in_window = (in_ch.energy >= cfg.energy_low) && (in_ch.energy < cfg.energy_high)
                  && (!cfg.time_low_on  || (in_ch.stamp >= cfg.time_low))
                  && (!cfg.time_high_on || (in_ch.stamp <  cfg.time_high));

  // module row / column from the reciprocal product
  assign quo     = prod_r[DIV_SH +: MOD_W];
  assign rem     = MOD_W'(POS_W'(mod_r) - POS_W'(quo) * POS_W'(MOD_PER_ROW));
  assign bx_full = POS_W'(quo) * POS_W'(CELL) + POS_W'(px_r);
  assign by_full = POS_W'(rem) * POS_W'(CELL) + POS_W'(py_r);

  assign addr_full = POS_W'(bx_r) * POS_W'(GRID) + POS_W'(by_r);

  assign out_load = (state_r == ST_WB) && (!out_valid_r || out_ch.ready);
  assign cnt_inc  = (mem_rdata == SAT_COUNT) ? mem_rdata : mem_rdata + CNT_W'(1);
  assign mem_re   = (state_r == ST_READ) && keep_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
    end else if (out_load && keep_r) begin
      mem_we    = 1'b1;
      mem_wdata = (op_r == OP_READ) ? '0 : cnt_inc;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == ADDR_W'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_nxt = (in_ch.op == OP_READ) ? ST_ADDR : ST_DIV;
      end
      ST_DIV:  state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_WB;
      ST_WB:   if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.op;
      mod_r <= in_ch.module_req;
      px_r  <= in_ch.pixel_x;
      py_r  <= in_ch.pixel_y;
      if (in_ch.op == OP_READ) begin
        bx_r   <= COORD_W'(in_ch.read_x);
        by_r   <= COORD_W'(in_ch.read_y);
        keep_r <= (9'(in_ch.read_x) < 9'(GRID)) && (9'(in_ch.read_y) < 9'(GRID));
      end else begin
        keep_r <= in_window;
      end
    end
    if (state_r == ST_DIV) prod_r <= PROD_W'(mod_r) * PROD_W'(DIV_RECIP);
    if (state_r == ST_POS) begin
      bx_r   <= bx_full[COORD_W-1:0];
      by_r   <= by_full[COORD_W-1:0];
      keep_r <= keep_r && (bx_full < POS_W'(GRID)) && (by_full < POS_W'(GRID));
    end
    if (state_r == ST_ADDR) addr_r <= addr_full[ADDR_W-1:0];
    if (out_load) begin
      if (op_r == OP_READ) begin
        out_kind_r <= KIND_READOUT;
        out_x_r    <= bx_r[RD_W-1:0];
        out_y_r    <= by_r[RD_W-1:0];
        out_cnt_r  <= keep_r ? mem_rdata : '0;
      end else if (keep_r) begin
        out_kind_r <= KIND_COUNTED;
        out_x_r    <= bx_r[RD_W-1:0];
        out_y_r    <= by_r[RD_W-1:0];
        out_cnt_r  <= cnt_inc;
      end else begin
        out_kind_r <= KIND_DROPPED;
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_cnt_r  <= '0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.bin_x = out_x_r;
  assign out_ch.bin_y = out_y_r;
  assign out_ch.count = out_cnt_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready)
    else $error("word accepted during clearing pass");

  a_write_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r != ST_CLEAR)) |-> (out_load && keep_r))
    else $error("bin written without result load");

  a_read_then_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_WB))
    else $error("read not followed by write-back");

  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && keep_r && (op_r == OP_EVENT)) |=> (out_ch.count != '0))
    else $error("counted bin reports zero");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import esh_pkg::*;

  typedef struct packed {
    logic             op;
    logic [E_W-1:0]   energy;
    logic [T_W-1:0]   stamp;
    logic [MOD_W-1:0] module_req;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [RD_W-1:0]  read_x;
    logic [RD_W-1:0]  read_y;
  } hit_word_t;

  typedef struct packed {
    kind_t            kind;
    logic [RD_W-1:0]  bin_x;
    logic [RD_W-1:0]  bin_y;
    logic [CNT_W-1:0] count;
  } bin_result_t;

  typedef struct packed {
    logic        typed;
    hit_word_t   w;
    bin_result_t res;
  } dir_row_t;

  localparam cfg_idx_t    REG_SPARE   = 3'd6;
  localparam bin_result_t BY_MODEL    = '0;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          PHASE_LEN [6] = '{170, 170, 110, 40, 170, 90};
  localparam logic [MOD_W-1:0] HOT_MODS [5] = '{8'd0, 8'd9, 8'd44, 8'd90, 8'd99};

  // typed rows carry their result; the rest go through the bin model
  localparam dir_row_t DIR_TAB [24] = '{
    '{1'b1, '{OP_READ,  16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 7'd0,   7'd0},
            '{KIND_READOUT, 7'd0,   7'd0,   32'd0}},
    '{1'b1, '{OP_READ,  16'h0000, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 7'd89,  7'd89},
            '{KIND_READOUT, 7'd89,  7'd89,  32'd0}},
    '{1'b1, '{OP_READ,  16'h0000, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 7'd90,  7'd0},
            '{KIND_READOUT, 7'd90,  7'd0,   32'd0}},
    '{1'b1, '{OP_READ,  16'h0000, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 7'd127, 7'd127},
            '{KIND_READOUT, 7'd127, 7'd127, 32'd0}},
    '{1'b1, '{OP_READ,  16'h0000, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 7'd0,   7'd127},
            '{KIND_READOUT, 7'd0,   7'd127, 32'd0}},
    '{1'b1, '{OP_EVENT, 16'hFFFF, 32'h0000_0000, 8'd0,   8'd0,   8'd0,  7'd0, 7'd0},
            '{KIND_DROPPED, 7'd0, 7'd0, 32'd0}},
    '{1'b1, '{OP_EVENT, 16'h0000, 32'h0000_0000, 8'd100, 8'd0,   8'd0,  7'd0, 7'd0},
            '{KIND_DROPPED, 7'd0, 7'd0, 32'd0}},
    '{1'b1, '{OP_EVENT, 16'h0000, 32'h0000_0000, 8'hFF,  8'hFF,  8'hFF, 7'd0, 7'd0},
            '{KIND_DROPPED, 7'd0, 7'd0, 32'd0}},
    '{1'b1, '{OP_EVENT, 16'h0000, 32'h0000_0000, 8'd9,   8'd0,   8'd9,  7'd0, 7'd0},
            '{KIND_DROPPED, 7'd0, 7'd0, 32'd0}},
    '{1'b1, '{OP_EVENT, 16'h0000, 32'h0000_0000, 8'd0,   8'd90,  8'd0,  7'd0, 7'd0},
            '{KIND_DROPPED, 7'd0, 7'd0, 32'd0}},
    '{1'b1, '{OP_EVENT, 16'h0000, 32'h0000_0000, 8'd0,   8'd0,   8'd0,  7'd127, 7'd127},
            '{KIND_COUNTED, 7'd0, 7'd0, 32'd1}},
    '{1'b0, '{OP_EVENT, 16'h0001, 32'hFFFF_FFFF, 8'd0,   8'd0,   8'd0,  7'd0, 7'd0},
            BY_MODEL},
    '{1'b0, '{OP_EVENT, 16'hFFFE, 32'h8000_0000, 8'd0,   8'd0,   8'd0,  7'd0, 7'd0},
            BY_MODEL},
    '{1'b1, '{OP_EVENT, 16'hFFFE, 32'hFFFF_FFFF, 8'd99,  8'd8,   8'd8,  7'd0, 7'd0},
            '{KIND_COUNTED, 7'd89, 7'd89, 32'd1}},
    '{1'b0, '{OP_EVENT, 16'h1234, 32'h0000_0000, 8'd0,   8'd89,  8'd89, 7'd0, 7'd0},
            BY_MODEL},
    '{1'b0, '{OP_EVENT, 16'h1234, 32'h0000_0001, 8'd90,  8'd8,   8'd0,  7'd0, 7'd0},
            BY_MODEL},
    '{1'b0, '{OP_EVENT, 16'h1234, 32'h0000_0002, 8'd9,   8'd0,   8'd8,  7'd0, 7'd0},
            BY_MODEL},
    '{1'b0, '{OP_READ,  16'h0000, 32'h0000_0000, 8'd0,   8'd0,   8'd0,  7'd0,  7'd0},
            BY_MODEL},
    '{1'b0, '{OP_READ,  16'h0000, 32'h0000_0000, 8'd0,   8'd0,   8'd0,  7'd0,  7'd0},
            BY_MODEL},
    '{1'b0, '{OP_READ,  16'h0000, 32'h0000_0000, 8'd0,   8'd0,   8'd0,  7'd89, 7'd89},
            BY_MODEL},
    '{1'b0, '{OP_READ,  16'h0000, 32'h0000_0000, 8'd0,   8'd0,   8'd0,  7'd89, 7'd0},
            BY_MODEL},
    '{1'b0, '{OP_READ,  16'h0000, 32'h0000_0000, 8'd0,   8'd0,   8'd0,  7'd0,  7'd89},
            BY_MODEL},
    '{1'b0, '{OP_EVENT, 16'h8000, 32'h5A5A_A5A5, 8'd55,  8'd4,   8'd4,  7'd127, 7'd0},
            BY_MODEL},
    '{1'b0, '{OP_READ,  16'hFFFF, 32'hFFFF_FFFF, 8'hFF,  8'hFF,  8'hFF, 7'd49, 7'd49},
            BY_MODEL}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  esh_in_if  in_ch ();
  esh_out_if out_ch ();

  event_sky_histogram_2d_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  logic [CNT_W-1:0] hist_bins [CELLS];
  cfg_regs_t        cfg_shadow;
  bin_result_t      due_results [$];
  int unsigned      bad_cnt = 0;
  int unsigned      cyc_cnt = 0;
  int unsigned      burst_left = 0;
  bit               hold_out = 1'b0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic bin_result_t tally_hit(input hit_word_t w);
    bin_result_t r;
    int unsigned bx, by, slot;
    logic keep;
    r = '0;
    if (w.op == OP_READ) begin
      r.kind  = KIND_READOUT;
      r.bin_x = w.read_x;
      r.bin_y = w.read_y;
      if (w.read_x < GRID && w.read_y < GRID) begin
        slot = w.read_x * GRID + w.read_y;
        r.count = hist_bins[slot];
        hist_bins[slot] = '0;
      end
      return r;
    end
    bx = (w.module_req / MOD_PER_ROW) * CELL + w.pixel_x;
    by = (w.module_req % MOD_PER_ROW) * CELL + w.pixel_y;
    keep = w.energy >= cfg_shadow.energy_low && w.energy < cfg_shadow.energy_high
        && !(cfg_shadow.time_low_on && w.stamp < cfg_shadow.time_low)
        && !(cfg_shadow.time_high_on && w.stamp >= cfg_shadow.time_high)
        && bx < GRID && by < GRID;
    if (!keep) begin
      r.kind = KIND_DROPPED;
      return r;
    end
    slot = bx * GRID + by;
    if (hist_bins[slot] != SAT_COUNT) hist_bins[slot] = hist_bins[slot] + 1'b1;
    r.kind  = KIND_COUNTED;
    r.bin_x = RD_W'(bx);
    r.bin_y = RD_W'(by);
    r.count = hist_bins[slot];
    return r;
  endfunction

  // mostly in-window events, many on a few hot modules, plus readouts and raw noise
  function automatic hit_word_t random_hit();
    hit_word_t w;
    int unsigned sel, hot, lo, hi;
    w.op         = OP_EVENT;
    w.energy     = 16'($urandom);
    w.stamp      = $urandom;
    w.module_req = 8'($urandom);
    w.pixel_x    = 8'($urandom);
    w.pixel_y    = 8'($urandom);
    w.read_x     = 7'($urandom);
    w.read_y     = 7'($urandom);
    sel = $urandom_range(0, 99);
    hot = 32'(HOT_MODS[$urandom_range(0, 4)]);
    if (sel < 25) begin
      w.op = 1'($urandom);
      return w;
    end
    if (sel < 45) begin
      w.op = OP_READ;
      if (sel < 38) begin
        w.read_x = 7'((hot / MOD_PER_ROW) * CELL + $urandom_range(0, 2));
        w.read_y = 7'((hot % MOD_PER_ROW) * CELL + $urandom_range(0, 2));
      end else if (sel < 43) begin
        w.read_x = 7'($urandom_range(0, GRID - 1));
        w.read_y = 7'($urandom_range(0, GRID - 1));
      end
      return w;
    end
    if (cfg_shadow.energy_low < cfg_shadow.energy_high)
      w.energy = 16'($urandom_range(cfg_shadow.energy_high - 1, cfg_shadow.energy_low));
    lo = cfg_shadow.time_low_on ? cfg_shadow.time_low : 32'd0;
    hi = cfg_shadow.time_high_on ? cfg_shadow.time_high - 32'd1 : 32'hFFFF_FFFF;
    if (!(cfg_shadow.time_high_on && cfg_shadow.time_high == 0) && lo <= hi)
      w.stamp = $urandom_range(hi, lo);
    if (sel < 80) begin
      w.module_req = 8'(hot);
      w.pixel_x    = 8'($urandom_range(0, 2));
      w.pixel_y    = 8'($urandom_range(0, 2));
    end else begin
      w.module_req = 8'($urandom_range(0, 99));
      w.pixel_x    = 8'($urandom_range(0, sel < 95 ? CELL - 1 : 12));
      w.pixel_y    = 8'($urandom_range(0, sel < 95 ? CELL - 1 : 12));
    end
    return w;
  endfunction

  task automatic flag_bad(input string why, input bin_result_t e, input bin_result_t g);
    bad_cnt++;
    if (bad_cnt <= 10)
      $display("%s: exp kind=%0d x=%0d y=%0d n=%0d, got kind=%0d x=%0d y=%0d n=%0d",
               why, e.kind, e.bin_x, e.bin_y, e.count, g.kind, g.bin_x, g.bin_y, g.count);
  endtask

  // called and returns right after a falling edge
  task automatic send_word(input hit_word_t w, input logic typed, input bin_result_t fixed_res);
    bin_result_t pred;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.op         <= w.op;
    in_ch.energy     <= w.energy;
    in_ch.stamp      <= w.stamp;
    in_ch.module_req <= w.module_req;
    in_ch.pixel_x    <= w.pixel_x;
    in_ch.pixel_y    <= w.pixel_y;
    in_ch.read_x     <= w.read_x;
    in_ch.read_y     <= w.read_y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = tally_hit(w);
    due_results.push_back(typed ? fixed_res : pred);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (due_results.size() != 0);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ENERGY_LOW:   cfg_shadow.energy_low   = val[E_W-1:0];
      REG_ENERGY_HIGH:  cfg_shadow.energy_high  = val[E_W-1:0];
      REG_TIME_LOW:     cfg_shadow.time_low     = val[T_W-1:0];
      REG_TIME_HIGH:    cfg_shadow.time_high    = val[T_W-1:0];
      REG_TIME_LOW_ON:  cfg_shadow.time_low_on  = val[0];
      REG_TIME_HIGH_ON: cfg_shadow.time_high_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : watch_out
    bin_result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.bin_x, out_ch.bin_y, out_ch.count};
      if (due_results.size() == 0) begin
        flag_bad("unexpected word", BY_MODEL, got);
      end else begin
        if (got.kind !== due_results[0].kind || got.bin_x !== due_results[0].bin_x ||
            got.bin_y !== due_results[0].bin_y || got.count !== due_results[0].count)
          flag_bad("mismatch", due_results[0], got);
        void'(due_results.pop_front());
      end
    end
  end

  initial begin : sink_side
    logic [15:0] pat;
    int unsigned k, hold_left;
    pat = '1;
    k = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        hold_left = HOLD_CYCLES;
        hold_out = 1'b0;
      end
      if (k % 97 == 0) pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h1;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= pat[k % 16];
      end
      k++;
    end
  end

  initial begin : stim
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_ENERGY_LOW;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_EVENT;
    in_ch.energy     = '0;
    in_ch.stamp      = '0;
    in_ch.module_req = '0;
    in_ch.pixel_x    = '0;
    in_ch.pixel_y    = '0;
    in_ch.read_x     = '0;
    in_ch.read_y     = '0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    cfg_shadow = '{16'h0000, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i]) send_word(DIR_TAB[i].w, DIR_TAB[i].typed, DIR_TAB[i].res);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_reg(REG_ENERGY_LOW, 32'd200);
          set_reg(REG_ENERGY_HIGH, 32'd50000);
          set_reg(REG_TIME_LOW, 32'd1000);
          set_reg(REG_TIME_HIGH, 32'h9000_0000);
          set_reg(REG_TIME_LOW_ON, 32'd1);
          set_reg(REG_TIME_HIGH_ON, 32'd1);
          set_reg(REG_SPARE, 32'hFFFF_FFFF);
        end
        1: begin
          // upper data bits are dropped by the narrow registers
          set_reg(REG_ENERGY_LOW, 32'hFFFF_0000);
          set_reg(REG_ENERGY_HIGH, 32'h0000_FFFF);
          set_reg(REG_TIME_LOW, 32'h0000_0000);
          set_reg(REG_TIME_HIGH, 32'hFFFF_FFFF);
          set_reg(REG_TIME_LOW_ON, 32'h0000_0003);
        end
        2: begin
          set_reg(REG_ENERGY_LOW, 32'h0000_FFFE);
          set_reg(REG_TIME_LOW, 32'hFFFF_FFFF);
          set_reg(REG_TIME_HIGH_ON, 32'd0);
        end
        3: begin
          set_reg(REG_ENERGY_LOW, 32'h0000_FFFF);
          set_reg(REG_ENERGY_HIGH, 32'd0);
          set_reg(REG_TIME_HIGH, 32'd0);
          set_reg(REG_TIME_HIGH_ON, 32'd1);
          set_reg(REG_TIME_LOW_ON, 32'd0);
        end
        4: begin
          set_reg(REG_ENERGY_LOW, $urandom_range(0, 30000));
          set_reg(REG_ENERGY_HIGH, $urandom_range(35000, 65535));
          set_reg(REG_TIME_LOW, $urandom_range(0, 32'h7FFF_FFFF));
          set_reg(REG_TIME_HIGH, $urandom_range(32'h8000_0000, 32'hFFFF_FFFF));
          set_reg(REG_TIME_LOW_ON, $urandom_range(0, 1));
          set_reg(REG_TIME_HIGH_ON, $urandom_range(0, 1));
        end
        default: begin
          set_reg(REG_ENERGY_LOW, 32'd0);
          set_reg(REG_ENERGY_HIGH, 32'h0000_FFFF);
          set_reg(REG_TIME_LOW, 32'd0);
          set_reg(REG_TIME_HIGH, 32'hFFFF_FFFF);
          set_reg(REG_TIME_LOW_ON, 32'd0);
          set_reg(REG_TIME_HIGH_ON, 32'd0);
        end
      endcase
      for (int i = 0; i < PHASE_LEN[ph]; i++) begin
        if (i == 20 && (ph == 1 || ph == 4)) hold_out = 1'b1;
        send_word(random_hit(), 1'b0, BY_MODEL);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (bad_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
